// ===== src/process_table_scheduler_unit_macros.svh =====
// Assertion macros for the scheduler RTL.
// In synthesis builds they expand to nothing.
`ifndef PROCESS_TABLE_SCHEDULER_UNIT_MACROS_SVH
`define PROCESS_TABLE_SCHEDULER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/pts_pkg.sv =====
`default_nettype none
package pts_pkg;

  localparam int NUM_SLOTS_DEF = 64;

  // Request codes.
  localparam logic [2:0] REQ_ALLOC     = 3'd0;
  localparam logic [2:0] REQ_SET_STATE = 3'd1;
  localparam logic [2:0] REQ_SET_PRIO  = 3'd2;
  localparam logic [2:0] REQ_TICK      = 3'd3;
  localparam logic [2:0] REQ_PICK      = 3'd4;

  // Slot states.
  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_USED     = 3'd1;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] ST_ZOMBIE   = 3'd5;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NONE     = 2'd1;
  localparam logic [1:0] STAT_BAD_PRIO = 2'd2;
  localparam logic [1:0] STAT_NO_PID   = 2'd3;

  // Scheduling policies.
  localparam logic [1:0] POLICY_RR   = 2'd0;
  localparam logic [1:0] POLICY_FCFS = 2'd1;
  localparam logic [1:0] POLICY_DYN  = 2'd2;

  // Scan index sources.
  localparam logic [1:0] IDX_ZERO = 2'd0;
  localparam logic [1:0] IDX_SLOT = 2'd1;
  localparam logic [1:0] IDX_RR   = 2'd2;
  localparam logic [1:0] IDX_BEST = 2'd3;

  localparam logic [6:0] PRIO_INIT = 7'd60;
  localparam logic [6:0] PRIO_MAX  = 7'd100;
  localparam logic [3:0] NICE_DEF  = 4'd5;
  localparam logic [1:0] DIV_FIRST = 2'd3;

  localparam int ADDR_W = 3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       idx_load;
    logic [1:0] idx_sel;
    logic       idx_inc;
    logic       best_clr;
    logic       best_take;
    logic       best_cmp;
    logic       div_start;
    logic       div_step;
    logic       tick_inc;
    logic       alloc_wr;
    logic       state_wr;
    logic       prio_wr;
    logic       tick_wr;
    logic       pick_wr;
    logic       res_fail;
    logic [1:0] res_status;
    logic       out_load;
  } pts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] req;
    logic [1:0] mode;
    logic       slot_bad;
    logic       prio_bad;
    logic       pid_zero;
    logic       scan_last;
    logic       free_hit;
    logic       pid_hit;
    logic       runnable;
    logic       fcfs_better;
    logic       div_last;
    logic       best_vld;
  } pts_stat_t;

endpackage
`default_nettype wire

// ===== src/process_table_scheduler_unit.sv =====
// Each accepted request is dispatched, runs its scan of the slot table and loads its result
// into the output register. Allocate and set priority scan up to the hit; set state touches
// one slot; tick visits every slot; pick scans for runnable slots (dividing for each one in
// dynamic mode), then divides again to update the chosen slot. A stalled output delays the result.
// Throughput: one request at a time, set by the single-port slot table scan and the niceness
// divider. Reset is synchronous: slot states and pids read as unused and zero at once.
`default_nettype none
`include "process_table_scheduler_unit_macros.svh"
module process_table_scheduler_unit #(
  parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // slot[5:0], new_state[8:6], set_prio[15:9], lookup_pid[31:16]
  input  wire logic [31:0]                s_tdata,
  // req_type[2:0]
  input  wire logic [2:0]                 s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // chosen_slot[5:0], chosen_pid[21:6], prio_value[28:22], preempt_hint[29], zero fill
  output logic [31:0]                     m_tdata,
  // status[1:0]
  output logic [1:0]                      m_tuser,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pts_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [1:0] policy_mode;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {30'd0, policy_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= pts_pkg::POLICY_DYN;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      policy_mode <= pwdata[1:0];
    end
  end

  pts_pkg::pts_cmd_t  cmd;
  pts_pkg::pts_stat_t stat;
  logic [1:0]  res_status;
  logic [5:0]  res_slot;
  logic [15:0] res_pid;
  logic [6:0]  res_prio;
  logic        res_hint;
  logic        out_free;

  assign out_free = !m_tvalid || m_tready;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  pts_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .policy_mode  (policy_mode),
    .req_type     (s_tuser),
    .slot         (s_tdata[5:0]),
    .new_state    (s_tdata[8:6]),
    .set_prio     (s_tdata[15:9]),
    .lookup_pid   (s_tdata[31:16]),
    .res_status   (res_status),
    .res_slot     (res_slot),
    .res_pid      (res_pid),
    .res_prio     (res_prio),
    .res_hint     (res_hint)
  );

  // Output register; a finished result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {2'b00, res_hint, res_prio, res_pid, res_slot};
      m_tuser <= res_status;
    end
  end

  // Checks.
  `PTS_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "ready after accept")
  `PTS_ASSERT_IMPLY(a_fail_fields_zero, clk, rst, m_tvalid && (m_tuser != pts_pkg::STAT_OK), m_tdata == 32'd0, "failed result carries data")
  `PTS_ASSERT_IMPLY(a_hint_needs_ok, clk, rst, m_tvalid && m_tdata[29], (m_tuser == pts_pkg::STAT_OK) && (policy_mode == pts_pkg::POLICY_DYN), "hint without ok status")

endmodule
`default_nettype wire

// ===== src/pts_ctrl.sv =====
`default_nettype none
module pts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               out_free,
  input  wire pts_pkg::pts_stat_t stat,
  output pts_pkg::pts_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LOAD, S_EVAL, S_DIV, S_PRIO,
    S_FSEL, S_FLOAD, S_FEVAL, S_FDIV, S_FPRIO, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_LOAD;
        cmd.idx_load = 1'b1;
        cmd.idx_sel = pts_pkg::IDX_ZERO;
        case (stat.req)
          pts_pkg::REQ_ALLOC: begin
          end
          pts_pkg::REQ_SET_STATE: begin
            cmd.idx_sel = pts_pkg::IDX_SLOT;
            if (stat.slot_bad) begin
              cmd.res_fail = 1'b1;
              cmd.res_status = pts_pkg::STAT_NONE;
              state_next = S_DONE;
            end
          end
          pts_pkg::REQ_SET_PRIO: begin
            if (stat.prio_bad) begin
              cmd.res_fail = 1'b1;
              cmd.res_status = pts_pkg::STAT_BAD_PRIO;
              state_next = S_DONE;
            end else if (stat.pid_zero) begin
              cmd.res_fail = 1'b1;
              cmd.res_status = pts_pkg::STAT_NO_PID;
              state_next = S_DONE;
            end
          end
          pts_pkg::REQ_TICK: begin
            cmd.tick_inc = 1'b1;
          end
          pts_pkg::REQ_PICK: begin
            cmd.best_clr = 1'b1;
            if (stat.mode == pts_pkg::POLICY_RR) begin
              cmd.idx_sel = pts_pkg::IDX_RR;
            end
          end
          default: begin
            cmd.res_fail = 1'b1;
            cmd.res_status = pts_pkg::STAT_OK;
            state_next = S_DONE;
          end
        endcase
      end
      S_LOAD: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        case (stat.req)
          pts_pkg::REQ_ALLOC: begin
            if (stat.free_hit) begin
              cmd.alloc_wr = 1'b1;
              state_next = S_DONE;
            end else if (stat.scan_last) begin
              cmd.res_fail = 1'b1;
              cmd.res_status = pts_pkg::STAT_NONE;
              state_next = S_DONE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next = S_LOAD;
            end
          end
          pts_pkg::REQ_SET_STATE: begin
            cmd.state_wr = 1'b1;
            state_next = S_DONE;
          end
          pts_pkg::REQ_SET_PRIO: begin
            if (stat.pid_hit) begin
              cmd.prio_wr = 1'b1;
              state_next = S_DONE;
            end else if (stat.scan_last) begin
              cmd.res_fail = 1'b1;
              cmd.res_status = pts_pkg::STAT_NO_PID;
              state_next = S_DONE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next = S_LOAD;
            end
          end
          pts_pkg::REQ_TICK: begin
            cmd.tick_wr = 1'b1;
            if (stat.scan_last) begin
              cmd.res_fail = 1'b1;
              cmd.res_status = pts_pkg::STAT_OK;
              state_next = S_DONE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next = S_LOAD;
            end
          end
          pts_pkg::REQ_PICK: begin
            if (stat.mode == pts_pkg::POLICY_RR) begin
              if (stat.runnable) begin
                cmd.best_take = 1'b1;
                state_next = S_FSEL;
              end else if (stat.scan_last) begin
                cmd.res_fail = 1'b1;
                cmd.res_status = pts_pkg::STAT_NONE;
                state_next = S_DONE;
              end else begin
                cmd.idx_inc = 1'b1;
                state_next = S_LOAD;
              end
            end else if (stat.mode == pts_pkg::POLICY_FCFS) begin
              cmd.best_take = stat.runnable && stat.fcfs_better;
              if (!stat.scan_last) begin
                cmd.idx_inc = 1'b1;
                state_next = S_LOAD;
              end else if (stat.best_vld || stat.runnable) begin
                state_next = S_FSEL;
              end else begin
                cmd.res_fail = 1'b1;
                cmd.res_status = pts_pkg::STAT_NONE;
                state_next = S_DONE;
              end
            end else begin
              if (stat.runnable) begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
              end else if (!stat.scan_last) begin
                cmd.idx_inc = 1'b1;
                state_next = S_LOAD;
              end else if (stat.best_vld) begin
                state_next = S_FSEL;
              end else begin
                cmd.res_fail = 1'b1;
                cmd.res_status = pts_pkg::STAT_NONE;
                state_next = S_DONE;
              end
            end
          end
          default: begin
            cmd.res_fail = 1'b1;
            cmd.res_status = pts_pkg::STAT_OK;
            state_next = S_DONE;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_PRIO;
        end
      end
      S_PRIO: begin
        cmd.best_cmp = 1'b1;
        if (stat.scan_last) begin
          state_next = S_FSEL;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_FSEL: begin
        cmd.idx_load = 1'b1;
        cmd.idx_sel = pts_pkg::IDX_BEST;
        state_next = S_FLOAD;
      end
      S_FLOAD: begin
        state_next = S_FEVAL;
      end
      S_FEVAL: begin
        cmd.div_start = 1'b1;
        state_next = S_FDIV;
      end
      S_FDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FPRIO;
        end
      end
      S_FPRIO: begin
        cmd.pick_wr = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/pts_datapath.sv =====
`default_nettype none
module pts_datapath #(
  parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pts_pkg::pts_cmd_t cmd,
  output pts_pkg::pts_stat_t     stat,
  input  wire logic [1:0]        policy_mode,
  input  wire logic [2:0]        req_type,
  input  wire logic [5:0]        slot,
  input  wire logic [2:0]        new_state,
  input  wire logic [6:0]        set_prio,
  input  wire logic [15:0]       lookup_pid,
  output logic [1:0]             res_status,
  output logic [5:0]             res_slot,
  output logic [15:0]            res_pid,
  output logic [6:0]             res_prio,
  output logic                   res_hint
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // Latched request.
  logic [2:0]  req_r;
  logic [5:0]  slot_r;
  logic [2:0]  nst_r;
  logic [6:0]  npri_r;
  logic [15:0] lpid_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_type;
      slot_r <= slot;
      nst_r  <= new_state;
      npri_r <= set_prio;
      lpid_r <= lookup_pid;
    end
  end

  // Scan index and scan count.
  logic [IDX_W-1:0] idx, cnt, rr_next, best_idx, idx_src;

  always_comb begin
    case (cmd.idx_sel)
      pts_pkg::IDX_SLOT: idx_src = IDX_W'(slot_r);
      pts_pkg::IDX_RR:   idx_src = rr_next;
      pts_pkg::IDX_BEST: idx_src = best_idx;
      default:           idx_src = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      cnt <= '0;
    end else if (cmd.idx_load) begin
      idx <= idx_src;
      cnt <= '0;
    end else if (cmd.idx_inc) begin
      idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      cnt <= cnt + 1'b1;
    end
  end

  // Slot table storage; state and pid carry valid bits cleared at reset.
  logic [2:0]  status_mem [NUM_SLOTS];
  logic [15:0] pid_mem    [NUM_SLOTS];
  logic [6:0]  sprio_mem  [NUM_SLOTS];
  logic [31:0] run_mem    [NUM_SLOTS];
  logic [31:0] create_mem [NUM_SLOTS];
  logic [31:0] rrun_mem   [NUM_SLOTS];
  logic [31:0] rslp_mem   [NUM_SLOTS];
  logic [31:0] lpt_mem    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] status_vld, pid_vld;

  logic [2:0]  status_q;
  logic [15:0] pid_q;
  logic        status_vq, pid_vq;
  logic [6:0]  sprio_q;
  logic [31:0] run_q, create_q, rrun_q, rslp_q, lpt_q;

  // Registered reads at the scan index.
  always_ff @(posedge clk) begin
    status_q  <= status_mem[idx];
    pid_q     <= pid_mem[idx];
    status_vq <= status_vld[idx];
    pid_vq    <= pid_vld[idx];
    sprio_q   <= sprio_mem[idx];
    run_q     <= run_mem[idx];
    create_q  <= create_mem[idx];
    rrun_q    <= rrun_mem[idx];
    rslp_q    <= rslp_mem[idx];
    lpt_q     <= lpt_mem[idx];
  end

  logic [2:0]  st_rd;
  logic [15:0] pid_rd;
  assign st_rd  = status_vq ? status_q : pts_pkg::ST_UNUSED;
  assign pid_rd = pid_vq ? pid_q : 16'd0;

  logic [31:0] tick_count;
  logic [15:0] next_pid, pid_inc;
  logic        dyn_mode, pick_cnt;
  assign dyn_mode = policy_mode[1];
  assign pick_cnt = cmd.pick_wr && dyn_mode;
  assign pid_inc  = next_pid + 16'd1;

  // Write enables and data, all at the scan index.
  logic status_we, pid_we, sprio_we, run_we, lpt_we, rrun_we, rslp_we;
  logic [2:0]  status_wd;
  logic [15:0] pid_wd;
  logic [6:0]  sprio_wd;
  logic [31:0] run_wd, lpt_wd, rrun_wd, rslp_wd;
  logic        tick_run, tick_slp;

  assign tick_run  = cmd.tick_wr && (st_rd == pts_pkg::ST_RUNNING);
  assign tick_slp  = cmd.tick_wr && (st_rd == pts_pkg::ST_SLEEPING);
  assign status_we = cmd.alloc_wr || cmd.pick_wr ||
                     (cmd.state_wr && (nst_r <= pts_pkg::ST_ZOMBIE));
  assign status_wd = cmd.alloc_wr ? pts_pkg::ST_USED :
                     cmd.state_wr ? nst_r : pts_pkg::ST_RUNNING;
  assign pid_we    = cmd.alloc_wr || (cmd.state_wr && (nst_r == pts_pkg::ST_UNUSED));
  assign pid_wd    = cmd.alloc_wr ? next_pid : 16'd0;
  assign sprio_we  = cmd.alloc_wr || cmd.prio_wr;
  assign sprio_wd  = cmd.alloc_wr ? pts_pkg::PRIO_INIT : npri_r;
  assign run_we    = cmd.alloc_wr || pick_cnt;
  assign run_wd    = cmd.alloc_wr ? 32'd0 : run_q + 32'd1;
  assign lpt_we    = cmd.alloc_wr || pick_cnt;
  assign lpt_wd    = cmd.alloc_wr ? 32'd0 : tick_count;
  assign rrun_we   = cmd.alloc_wr || cmd.prio_wr || pick_cnt || tick_run;
  assign rrun_wd   = cmd.tick_wr ? rrun_q + 32'd1 : 32'd0;
  assign rslp_we   = cmd.alloc_wr || cmd.prio_wr || pick_cnt || tick_slp;
  assign rslp_wd   = cmd.tick_wr ? rslp_q + 32'd1 : 32'd0;

  always_ff @(posedge clk) begin
    if (status_we) status_mem[idx] <= status_wd;
    if (pid_we)    pid_mem[idx]    <= pid_wd;
    if (sprio_we)  sprio_mem[idx]  <= sprio_wd;
    if (run_we)    run_mem[idx]    <= run_wd;
    if (lpt_we)    lpt_mem[idx]    <= lpt_wd;
    if (rrun_we)   rrun_mem[idx]   <= rrun_wd;
    if (rslp_we)   rslp_mem[idx]   <= rslp_wd;
    if (cmd.alloc_wr) create_mem[idx] <= tick_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_vld <= '0;
      pid_vld    <= '0;
    end else begin
      if (status_we) status_vld[idx] <= 1'b1;
      if (pid_we)    pid_vld[idx]    <= 1'b1;
    end
  end

  // Global counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      next_pid   <= 16'd1;
      rr_next    <= '0;
    end else begin
      if (cmd.tick_inc) tick_count <= tick_count + 32'd1;
      if (cmd.alloc_wr) next_pid <= (pid_inc == 16'd0) ? 16'd1 : pid_inc;
      if (cmd.pick_wr && (policy_mode == pts_pkg::POLICY_RR)) begin
        rr_next <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      end
    end
  end

  // Niceness divider: restoring, one quotient bit per cycle.
  logic [35:0] rem, trial;
  logic [32:0] den;
  logic [3:0]  quo;
  logic [1:0]  dstep;

  assign trial = {3'b000, den} << dstep;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem   <= ({4'd0, rslp_q} << 3) + ({4'd0, rslp_q} << 1);
      den   <= {1'b0, rrun_q} + {1'b0, rslp_q};
      quo   <= '0;
      dstep <= pts_pkg::DIV_FIRST;
    end else if (cmd.div_step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        quo[dstep] <= 1'b1;
      end
      dstep <= dstep - 2'd1;
    end
  end

  // Dynamic priority from the finished quotient.
  logic              use_nice;
  logic [3:0]        nice;
  logic signed [8:0] dsum;
  logic [6:0]        dprio;

  assign use_nice = (lpt_q != 32'd0) && (run_q != 32'd0) && (den != 33'd0);
  assign nice     = use_nice ? quo : pts_pkg::NICE_DEF;
  assign dsum     = $signed({2'b00, sprio_q}) - $signed({5'b00000, nice})
                  + $signed({5'b00000, pts_pkg::NICE_DEF});

  always_comb begin
    if (dsum < 9'sd0) begin
      dprio = 7'd0;
    end else if (dsum > $signed({2'b00, pts_pkg::PRIO_MAX})) begin
      dprio = pts_pkg::PRIO_MAX;
    end else begin
      dprio = dsum[6:0];
    end
  end

  // Best candidate of a pick scan.
  logic        best_vld, dyn_better, fcfs_better;
  logic [6:0]  best_prio;
  logic [31:0] best_run, best_create;

  assign fcfs_better = !best_vld || (create_q < best_create);
  assign dyn_better  = !best_vld || (dprio < best_prio) ||
                       ((dprio == best_prio) && (run_q < best_run)) ||
                       ((dprio == best_prio) && (run_q == best_run) &&
                        (create_q < best_create));

  always_ff @(posedge clk) begin
    if (rst || cmd.best_clr) begin
      best_vld <= 1'b0;
    end else if (cmd.best_take || (cmd.best_cmp && dyn_better)) begin
      best_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.best_take || (cmd.best_cmp && dyn_better)) begin
      best_idx    <= idx;
      best_prio   <= dprio;
      best_run    <= run_q;
      best_create <= create_q;
    end
  end

  // Result fields.
  always_ff @(posedge clk) begin
    if (cmd.res_fail) begin
      res_status <= cmd.res_status;
      res_slot   <= '0;
      res_pid    <= '0;
      res_prio   <= '0;
      res_hint   <= 1'b0;
    end else if (cmd.alloc_wr || cmd.state_wr || cmd.prio_wr || cmd.pick_wr) begin
      res_status <= pts_pkg::STAT_OK;
      res_slot   <= 6'(idx);
      res_hint   <= 1'b0;
      res_prio   <= 7'd0;
      res_pid    <= pid_rd;
      if (cmd.alloc_wr) begin
        res_pid <= next_pid;
      end else if (cmd.state_wr) begin
        if (nst_r == pts_pkg::ST_UNUSED) res_pid <= 16'd0;
      end else if (cmd.prio_wr) begin
        res_prio <= sprio_q;
        res_hint <= (sprio_q > npri_r) && (policy_mode == pts_pkg::POLICY_DYN);
      end else begin
        res_prio <= dprio;
      end
    end
  end

  // Status toward the controller.
  assign stat.req         = req_r;
  assign stat.mode        = policy_mode;
  assign stat.slot_bad    = {3'b000, slot_r} >= 9'(NUM_SLOTS);
  assign stat.prio_bad    = npri_r > pts_pkg::PRIO_MAX;
  assign stat.pid_zero    = (lpid_r == 16'd0);
  assign stat.scan_last   = (cnt == LAST_IDX);
  assign stat.free_hit    = (st_rd == pts_pkg::ST_UNUSED);
  assign stat.pid_hit     = (pid_rd == lpid_r);
  assign stat.runnable    = (st_rd == pts_pkg::ST_RUNNABLE);
  assign stat.fcfs_better = fcfs_better;
  assign stat.div_last    = (dstep == 2'd0);
  assign stat.best_vld    = best_vld;

endmodule
`default_nettype wire
